@@ design/csr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csr_pkg;

    localparam int MAX_RADIUS  = 63;
    localparam int COORD_BITS  = 16;
    localparam int RADIUS_BITS = 6;
    localparam int DEC_BITS    = 9;
    localparam int COLOR_BITS  = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  center_x;
        logic signed [COORD_BITS-1:0]  center_y;
        logic        [RADIUS_BITS-1:0] radius;
        logic                          filled;
        logic        [COLOR_BITS-1:0]  color;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  out_center_x;
        logic signed [COORD_BITS-1:0]  out_center_y;
        logic        [RADIUS_BITS-1:0] offset_x;
        logic        [RADIUS_BITS-1:0] offset_y;
        logic                          out_filled;
        logic        [COLOR_BITS-1:0]  out_color;
        logic                          last;
    } t_out;

    // classified circle command as held in the queue
    typedef struct packed {
        logic signed [COORD_BITS-1:0]  center_x;
        logic signed [COORD_BITS-1:0]  center_y;
        logic        [RADIUS_BITS-1:0] radius;
        logic                          filled;
        logic        [COLOR_BITS-1:0]  color;
        logic signed [DEC_BITS-1:0]    dec_init;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage

`default_nettype wire

@@ design/csr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  csr_pkg::t_in       i_data,
    output logic               o_stall,
    output logic               o_push,
    output csr_pkg::t_cmd      o_cmd,
    input  csr_pkg::t_q_status i_q_stat
);

    logic                                  r_valid;
    logic                                  n_valid;
    csr_pkg::t_cmd                         r_cmd;
    csr_pkg::t_cmd                         n_cmd;
    logic [csr_pkg::RADIUS_BITS-1:0]       w_radius;
    logic                                  w_take;

    // clamp radius
    assign w_radius = (i_data.radius > csr_pkg::RADIUS_BITS'(csr_pkg::MAX_RADIUS))
                    ? csr_pkg::RADIUS_BITS'(csr_pkg::MAX_RADIUS) : i_data.radius;

    assign o_push  = r_valid && !i_q_stat.full;
    assign o_stall = r_valid && i_q_stat.full;
    assign w_take  = i_valid && !o_stall;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (w_take) begin
            n_valid          = 1'b1;
            n_cmd.center_x   = i_data.center_x;
            n_cmd.center_y   = i_data.center_y;
            n_cmd.radius     = w_radius;
            n_cmd.filled     = i_data.filled;
            n_cmd.color      = i_data.color;
            n_cmd.dec_init   = $signed({{(csr_pkg::DEC_BITS-csr_pkg::RADIUS_BITS){1'b0}},
                                        w_radius}) - csr_pkg::DEC_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

`default_nettype wire

@@ design/csr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  csr_pkg::t_cmd      i_cmd,
    input  wire logic          i_pop,
    output csr_pkg::t_cmd      o_head,
    output csr_pkg::t_q_status o_stat
);

    csr_pkg::t_cmd                    r_mem [csr_pkg::QUEUE_DEPTH];
    logic [csr_pkg::Q_PTR_BITS-1:0]   r_wr_ptr;
    logic [csr_pkg::Q_PTR_BITS-1:0]   r_rd_ptr;
    logic [csr_pkg::Q_CNT_BITS-1:0]   r_count;
    logic                             w_push;
    logic                             w_pop;

    function automatic logic [csr_pkg::Q_PTR_BITS-1:0] ptr_inc(
        input logic [csr_pkg::Q_PTR_BITS-1:0] p
    );
        return (p == csr_pkg::Q_PTR_BITS'(csr_pkg::QUEUE_DEPTH - 1))
             ? '0 : p + csr_pkg::Q_PTR_BITS'(1);
    endfunction

    assign o_stat.full  = (r_count == csr_pkg::Q_CNT_BITS'(csr_pkg::QUEUE_DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && o_stat.valid;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + csr_pkg::Q_CNT_BITS'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - csr_pkg::Q_CNT_BITS'(1);
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ design/csr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module csr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  csr_pkg::t_cmd      i_head,
    input  csr_pkg::t_q_status i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    output csr_pkg::t_out      o_data,
    input  wire logic          i_stall
);

    localparam int RB = csr_pkg::RADIUS_BITS;
    localparam int DB = csr_pkg::DEC_BITS;

    logic                          r_busy;
    csr_pkg::t_cmd                 r_cmd;
    logic [RB-1:0]                 r_x;
    logic [RB-1:0]                 r_y;
    logic signed [DB-1:0]          r_d;
    logic                          r_ovalid;
    csr_pkg::t_out                 r_out;

    logic                          w_adv;
    logic signed [DB-1:0]          w_x2;
    logic signed [DB-1:0]          w_y2;
    logic signed [DB-1:0]          w_ry2;
    logic signed [DB-1:0]          n_d;
    logic [RB-1:0]                 n_x;
    logic [RB-1:0]                 n_y;
    logic                          w_last;

    assign o_pop   = !r_busy && i_q_stat.valid;
    assign w_adv   = r_busy && (!r_ovalid || !i_stall);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign w_x2  = $signed({{(DB-RB-1){1'b0}}, r_x, 1'b0});
    assign w_y2  = $signed({{(DB-RB-1){1'b0}}, r_y, 1'b0});
    assign w_ry2 = $signed({{(DB-RB-1){1'b0}}, r_cmd.radius - r_y, 1'b0});

    // three-way decision step; last when the next point leaves the octant
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (r_d >= w_x2) begin
            n_d    = r_d - w_x2 - DB'(1);
            n_x    = r_x + RB'(1);
            w_last = (r_y == r_x);
        end else if (r_d < w_ry2) begin
            n_d    = r_d + w_y2 - DB'(1);
            n_y    = r_y - RB'(1);
            w_last = (r_y == r_x);
        end else begin
            n_d    = r_d + w_y2 - w_x2 - DB'(2);
            n_x    = r_x + RB'(1);
            n_y    = r_y - RB'(1);
            w_last = (r_y == r_x) || (r_y == r_x + RB'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_adv && w_last) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_cmd <= i_head;
            r_x   <= '0;
            r_y   <= i_head.radius;
            r_d   <= i_head.dec_init;
        end else if (w_adv) begin
            r_x <= n_x;
            r_y <= n_y;
            r_d <= n_d;
        end
        if (w_adv) begin
            r_out.out_center_x <= r_cmd.center_x;
            r_out.out_center_y <= r_cmd.center_y;
            r_out.offset_x     <= r_x;
            r_out.offset_y     <= r_y;
            r_out.out_filled   <= r_cmd.filled;
            r_out.out_color    <= r_cmd.color;
            r_out.last         <= w_last;
        end
    end

endmodule

`default_nettype wire

@@ design/circle_span_rasterizer_top.sv @@
// Circle span rasterizer. Each input beat is one circle command (center,
// radius, fill mode, color); the block walks one octant of the circle with
// the Andres integer scheme and emits one output beat per iteration, carrying
// the center, the current (offset_x, offset_y) pair with offset_y >= offset_x,
// the mode and color, and last on the final beat of the circle. A radius of
// zero gives a single beat with both offsets zero. A circle of radius r yields
// about r/sqrt(2) + 1 beats (at most r + 1, at most 64), one per cycle from
// the back-end iterator unless stalled, and then loads the next command from
// the two-entry command queue. The front end keeps accepting commands while
// the iterator runs, until the queue and its input register are full.
`timescale 1ns / 1ps
`default_nettype none

module circle_span_rasterizer_top (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // command channel
    input  wire logic     i_valid,
    input  csr_pkg::t_in  i_data,
    output logic          o_stall,
    // result channel
    output logic          o_valid,
    output csr_pkg::t_out o_data,
    input  wire logic     i_stall
);

    logic               w_push;
    logic               w_pop;
    csr_pkg::t_cmd      w_cmd;
    csr_pkg::t_cmd      w_head;
    csr_pkg::t_q_status w_q_stat;

    // front end: takes the command beat, clamps radius, seeds the decision term
    csr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .o_push   (w_push),
        .o_cmd    (w_cmd),
        .i_q_stat (w_q_stat)
    );

    // decouples command intake from the iterator
    csr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // back end: octant iterator with registered output beat
    csr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .i_stall  (i_stall)
    );

    // every emitted point lies in the upper octant
    a_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.offset_y >= o_data.offset_x))
        else $error("offset_x exceeds offset_y");

    // a circle's beats come back to back: no gap before last
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_data.last) |=> o_valid)
        else $error("gap inside a circle's beat sequence");

    // a full queue is never empty
    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> w_q_stat.valid)
        else $error("queue status inconsistent");

    // a push is only issued into a queue with room
    a_q_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

endmodule

`default_nettype wire
